### hw/rtl/pdts_pkg.sv
package pdts_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int NUMBER_W   = 32;
  localparam int TOTAL_W    = 27;
  localparam int NODE_W     = 5;
  localparam int CLASS_W    = 3;
  localparam int SEL_W      = 4;
  localparam int VALUE_W    = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'b1;

  typedef struct packed {
    logic ld_item;
    logic ld_cand;
    logic cls_dec;
    logic ld_row;
    logic drop_row;
    logic ld_col;
    logic wr_upd;
    logic fetch_upd;
    logic emit_none;
  } pdts_cmd_t;

  typedef struct packed {
    logic cand_zero;
    logic cls_zero;
    logic masked_zero;
  } pdts_stat_t;

endpackage

### hw/rtl/pdts_ram.sv
module pdts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1280
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/pdts_ctrl.sv
module pdts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_cmd,
  input  pdts_pkg::pdts_stat_t stat,
  output pdts_pkg::pdts_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  import pdts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_RD,
    S_WR_UPD,
    S_F_LOAD,
    S_F_SCAN,
    S_F_ROW,
    S_F_COL,
    S_F_CRD,
    S_F_DEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_item = 1'b1;
          state_nxt   = (in_cmd == CMD_FETCH) ? S_F_LOAD : S_WR_RD;
        end
      end
      S_WR_RD: begin
        state_nxt = S_WR_UPD;
      end
      S_WR_UPD: begin
        cmd.wr_upd = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_F_LOAD: begin
        cmd.ld_cand = 1'b1;
        state_nxt   = S_F_SCAN;
      end
      S_F_SCAN: begin
        if (!stat.cand_zero) begin
          cmd.ld_row = 1'b1;
          state_nxt  = S_F_ROW;
        end else if (stat.cls_zero) begin
          cmd.emit_none = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.cls_dec = 1'b1;
          state_nxt   = S_F_LOAD;
        end
      end
      S_F_ROW: begin
        state_nxt = S_F_COL;
      end
      S_F_COL: begin
        if (stat.masked_zero) begin
          cmd.drop_row = 1'b1;
          state_nxt    = S_F_SCAN;
        end else begin
          cmd.ld_col = 1'b1;
          state_nxt  = S_F_CRD;
        end
      end
      S_F_CRD: begin
        state_nxt = S_F_DEC;
      end
      S_F_DEC: begin
        cmd.fetch_upd = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/pdts_dp.sv
module pdts_dp #(
  parameter int MAX_NODES   = 16,
  parameter int NUM_CLASSES = 5,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pdts_pkg::pdts_cmd_t                  cmd,
  output pdts_pkg::pdts_stat_t                 stat,
  input  logic                                 in_cmd,
  input  logic [pdts_pkg::CLASS_W-1:0]         in_class_sel,
  input  logic [pdts_pkg::SEL_W-1:0]           in_row_sel,
  input  logic [pdts_pkg::SEL_W-1:0]           in_col_sel,
  input  logic [pdts_pkg::VALUE_W-1:0]         in_count_value,
  input  logic                                 cfg_we,
  input  logic [pdts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdts_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_found,
  output logic [pdts_pkg::NUMBER_W-1:0]        out_demand_number,
  output logic [pdts_pkg::NODE_W-1:0]          out_source_node,
  output logic [pdts_pkg::NODE_W-1:0]          out_destination_node,
  output logic [pdts_pkg::CLASS_W-1:0]         out_demand_class,
  output logic [pdts_pkg::TOTAL_W-1:0]         out_remaining
);

  import pdts_pkg::*;

  localparam int IW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CIW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BM_DEPTH  = NUM_CLASSES * MAX_NODES;
  localparam int CNT_DEPTH = NUM_CLASSES * MAX_NODES * MAX_NODES;
  localparam int BAW       = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int CAW       = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

  logic [NODE_W-1:0]     node_count_r;
  logic [NUMBER_W-1:0]   next_number_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [CLASS_W-1:0]    cls_r;
  logic [IW-1:0]         row_r;
  logic [IW-1:0]         col_r;
  logic                  wr_ok_r;
  logic [COUNT_BITS-1:0] val_r;
  logic [MAX_NODES-1:0]  cand_r;
  logic [MAX_NODES-1:0]  flags_r [NUM_CLASSES];

  logic                  found_r;
  logic [NUMBER_W-1:0]   number_out_r;
  logic [NODE_W-1:0]     src_r;
  logic [NODE_W-1:0]     dst_r;
  logic [CLASS_W-1:0]    class_out_r;
  logic [TOTAL_W-1:0]    remaining_r;

  logic [MAX_NODES-1:0]  span_mask;
  logic [MAX_NODES-1:0]  flag_row;
  logic [MAX_NODES-1:0]  masked;
  logic [IW-1:0]         cand_first;
  logic [IW-1:0]         col_first;
  logic [BAW-1:0]        bm_addr;
  logic [CAW-1:0]        cnt_addr;
  logic [MAX_NODES-1:0]  bm_rdata;
  logic [MAX_NODES-1:0]  bm_wdata;
  logic                  bm_we;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  cnt_we;
  logic [MAX_NODES-1:0]  old_row;
  logic [MAX_NODES-1:0]  new_row;
  logic [COUNT_BITS-1:0] old_val;
  logic [COUNT_BITS-1:0] dec_val;
  logic [MAX_NODES-1:0]  col_onehot;
  logic                  in_ok;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      span_mask[i]  = (32'(i) < 32'(node_count_r));
      col_onehot[i] = (32'(i) == 32'(col_r));
    end
  end

  assign flag_row = flags_r[cls_r[CIW-1:0]];
  assign masked   = bm_rdata & span_mask;

  always_comb begin
    cand_first = '0;
    col_first  = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        cand_first = IW'(i);
      end
      if (masked[i]) begin
        col_first = IW'(i);
      end
    end
  end

  assign bm_addr  = BAW'(32'(cls_r) * MAX_NODES + 32'(row_r));
  assign cnt_addr = CAW'((32'(cls_r) * MAX_NODES + 32'(row_r)) * MAX_NODES + 32'(col_r));

  assign in_ok = (32'(in_class_sel) < NUM_CLASSES) && (32'(in_row_sel) < MAX_NODES) &&
                 (32'(in_col_sel) < MAX_NODES);

  assign old_row = flag_row[row_r] ? bm_rdata : '0;
  assign old_val = old_row[col_r] ? cnt_rdata : '0;
  assign dec_val = cnt_rdata - COUNT_BITS'(1);

  always_comb begin
    new_row   = bm_rdata;
    cnt_wdata = dec_val;
    cnt_we    = 1'b0;
    bm_we     = 1'b0;
    if (cmd.wr_upd) begin
      new_row   = (val_r != '0) ? (old_row | col_onehot) : (old_row & ~col_onehot);
      cnt_wdata = val_r;
      cnt_we    = wr_ok_r;
      bm_we     = wr_ok_r;
    end else if (cmd.fetch_upd) begin
      new_row = (dec_val == '0) ? (bm_rdata & ~col_onehot) : bm_rdata;
      cnt_we  = 1'b1;
      bm_we   = 1'b1;
    end
  end
  assign bm_wdata = new_row;

  pdts_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(BM_DEPTH)
  ) u_bitmap_ram (
    .clk  (clk),
    .we   (bm_we),
    .addr (bm_addr),
    .wdata(bm_wdata),
    .rdata(bm_rdata)
  );

  pdts_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(CNT_DEPTH)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .addr (cnt_addr),
    .wdata(cnt_wdata),
    .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_W'(16);
      next_number_r <= '0;
      total_r       <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        flags_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT:  node_count_r  <= cfg_wdata[NODE_W-1:0];
          CFG_START_INDEX: next_number_r <= cfg_wdata[NUMBER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.wr_upd && wr_ok_r) begin
        total_r                        <= total_r - TOTAL_W'(old_val) + TOTAL_W'(val_r);
        flags_r[cls_r[CIW-1:0]][row_r] <= (new_row != '0);
      end
      if (cmd.fetch_upd) begin
        total_r                        <= total_r - TOTAL_W'(1);
        next_number_r                  <= next_number_r + NUMBER_W'(1);
        flags_r[cls_r[CIW-1:0]][row_r] <= (new_row != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      cls_r   <= (in_cmd == CMD_FETCH) ? CLASS_W'(NUM_CLASSES - 1) : in_class_sel;
      row_r   <= IW'(in_row_sel);
      col_r   <= IW'(in_col_sel);
      wr_ok_r <= in_ok;
      val_r   <= COUNT_BITS'(in_count_value);
    end
    if (cmd.ld_cand) begin
      cand_r <= flag_row & span_mask;
    end
    if (cmd.cls_dec) begin
      cls_r <= cls_r - CLASS_W'(1);
    end
    if (cmd.ld_row) begin
      row_r <= cand_first;
    end
    if (cmd.drop_row) begin
      cand_r[row_r] <= 1'b0;
    end
    if (cmd.ld_col) begin
      col_r <= col_first;
    end
    if (cmd.fetch_upd) begin
      found_r      <= 1'b1;
      number_out_r <= next_number_r;
      src_r        <= NODE_W'(row_r) + NODE_W'(1);
      dst_r        <= NODE_W'(col_r) + NODE_W'(1);
      class_out_r  <= cls_r;
      remaining_r  <= total_r - TOTAL_W'(1);
    end
    if (cmd.emit_none) begin
      found_r      <= 1'b0;
      number_out_r <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      class_out_r  <= '0;
      remaining_r  <= total_r;
    end
  end

  assign stat.cand_zero   = (cand_r == '0);
  assign stat.cls_zero    = (cls_r == '0);
  assign stat.masked_zero = (masked == '0);

  assign out_found            = found_r;
  assign out_demand_number    = number_out_r;
  assign out_source_node      = src_r;
  assign out_destination_node = dst_r;
  assign out_demand_class     = class_out_r;
  assign out_remaining        = remaining_r;

endmodule

### hw/rtl/priority_demand_table_scanner.sv
// Holds one square table of pending demand counts per class and hands out
// demands in priority order, highest class first, then by row and column.
// An item is a beat taken when start is high and busy is low. A write beat
// (in_cmd low) with in-range selects stores one count; it gives no result.
// A fetch beat gives exactly one result beat on out_valid, held for one
// cycle: out_found tells whether a demand was taken from the tables.
// A fetch steps past each empty class and drops each row whose pending
// entries all lie beyond node_count before it strobes its result. A
// fetch on empty tables strobes a result with out_found low. The search
// runs over a per-row occupancy map: one flag per row in registers, one
// bit per entry in a bitmap memory, read one row per step, and a count
// memory read and rewritten once per demand. Busy stays high from the
// beat until the result is strobed. The receiver cannot stall the result.
// Reset clears the row flags at once, so no clearing pass is needed; it
// also sets node_count to 16 and the demand number to zero. The user must
// write the cfg port only while busy is low; the block does not enforce it.
// Register 1 reloads the demand number.
module priority_demand_table_scanner #(
  parameter int MAX_NODES   = 16,
  parameter int NUM_CLASSES = 5,
  parameter int COUNT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [pdts_pkg::CLASS_W-1:0]    in_class_sel,
  input  logic [pdts_pkg::SEL_W-1:0]      in_row_sel,
  input  logic [pdts_pkg::SEL_W-1:0]      in_col_sel,
  input  logic [pdts_pkg::VALUE_W-1:0]    in_count_value,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [pdts_pkg::NUMBER_W-1:0]   out_demand_number,
  output logic [pdts_pkg::NODE_W-1:0]     out_source_node,
  output logic [pdts_pkg::NODE_W-1:0]     out_destination_node,
  output logic [pdts_pkg::CLASS_W-1:0]    out_demand_class,
  output logic [pdts_pkg::TOTAL_W-1:0]    out_remaining,
  input  logic                            cfg_we,
  input  logic [pdts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import pdts_pkg::*;

  pdts_cmd_t  cmd;
  pdts_stat_t stat;
  logic       accept;

  assign accept = start && !busy;

  pdts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  pdts_dp #(
    .MAX_NODES  (MAX_NODES),
    .NUM_CLASSES(NUM_CLASSES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_class_sel        (in_class_sel),
    .in_row_sel          (in_row_sel),
    .in_col_sel          (in_col_sel),
    .in_count_value      (in_count_value),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_found           (out_found),
    .out_demand_number   (out_demand_number),
    .out_source_node     (out_source_node),
    .out_destination_node(out_destination_node),
    .out_demand_class    (out_demand_class),
    .out_remaining       (out_remaining)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an accepted beat");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobed outside the end of an item");

  a_none_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_demand_number == '0 && out_source_node == '0 &&
      out_destination_node == '0 && out_demand_class == '0)
    else $error("empty result carries nonzero fields");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_source_node != '0 && out_destination_node != '0 &&
      32'(out_demand_class) < NUM_CLASSES)
    else $error("found result outside the tables");

endmodule
